// ===== hw/rtl/sls_pkg.sv =====
// Shared types and constants for the load/store group: decode record, queue entry, codes.
package sls_pkg;

  localparam logic [15:0] HIGH_PAGE = 16'hFF00;

  // 3-bit codes of the 8-bit operands as they appear in the opcode fields
  localparam logic [2:0] R_B   = 3'd0;
  localparam logic [2:0] R_C   = 3'd1;
  localparam logic [2:0] R_D   = 3'd2;
  localparam logic [2:0] R_E   = 3'd3;
  localparam logic [2:0] R_H   = 3'd4;
  localparam logic [2:0] R_L   = 3'd5;
  localparam logic [2:0] R_MEM = 3'd6;
  localparam logic [2:0] R_A   = 3'd7;

  localparam logic [7:0] OP_HALT       = 8'h76;
  localparam logic [7:0] OP_MOVE_FIRST = 8'h40;
  localparam logic [7:0] OP_MOVE_LAST  = 8'h7F;
  localparam logic [7:0] OP_LD_BC_N16  = 8'h01;
  localparam logic [7:0] OP_LD_DE_N16  = 8'h11;
  localparam logic [7:0] OP_LD_HL_N16  = 8'h21;
  localparam logic [7:0] OP_ST_BC_A    = 8'h02;
  localparam logic [7:0] OP_ST_DE_A    = 8'h12;
  localparam logic [7:0] OP_LD_A_BC    = 8'h0A;
  localparam logic [7:0] OP_LD_A_DE    = 8'h1A;
  localparam logic [7:0] OP_ST_HLI_A   = 8'h22;
  localparam logic [7:0] OP_ST_HLD_A   = 8'h32;
  localparam logic [7:0] OP_LD_A_HLI   = 8'h2A;
  localparam logic [7:0] OP_LD_A_HLD   = 8'h3A;
  localparam logic [7:0] OP_STH_N8_A   = 8'hE0;
  localparam logic [7:0] OP_STH_C_A    = 8'hE2;
  localparam logic [7:0] OP_LDH_A_N8   = 8'hF0;
  localparam logic [7:0] OP_LDH_A_C    = 8'hF2;
  localparam logic [7:0] OP_ST_A16_A   = 8'hEA;
  localparam logic [7:0] OP_LD_A_A16   = 8'hFA;

  typedef enum logic [1:0] {
    BUS_NONE  = 2'd0,
    BUS_READ  = 2'd1,
    BUS_WRITE = 2'd2
  } bus_op_t;

  typedef enum logic [2:0] {
    ADDR_NONE,
    ADDR_HL,
    ADDR_BC,
    ADDR_DE,
    ADDR_IMM16,
    ADDR_HIGH_IMM,
    ADDR_HIGH_C
  } addr_sel_t;

  typedef enum logic [1:0] {
    SRC_REG,
    SRC_IMM8,
    SRC_READ
  } src_sel_t;

  typedef enum logic [1:0] {
    PAIR_BC,
    PAIR_DE,
    PAIR_HL
  } pair_sel_t;

  typedef enum logic [1:0] {
    HL_KEEP,
    HL_INC,
    HL_DEC
  } hl_step_t;

  typedef struct packed {
    logic      handled;
    bus_op_t   bus;
    addr_sel_t addr_sel;
    src_sel_t  src_sel;
    logic [2:0] src_code;
    logic      dst_write;
    logic [2:0] dst_code;
    logic      pair_write;
    pair_sel_t pair_sel;
    hl_step_t  hl_step;
  } decoded_t;

  typedef struct packed {
    decoded_t    dec;
    logic [15:0] imm;
    logic [7:0]  rdata;
  } queue_entry_t;

endpackage

// ===== hw/rtl/sls_decode.sv =====
// Front end: accepts instructions and classifies each opcode into a decode record.
module sls_decode (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           opcode,
  input  logic [15:0]          immediate,
  input  logic [7:0]           read_byte,
  input  logic                 q_full,
  output logic                 push,
  output sls_pkg::queue_entry_t entry
);

  sls_pkg::decoded_t dec;
  logic [2:0]        dst;
  logic [2:0]        src;

  assign dst = opcode[5:3];
  assign src = opcode[2:0];

  always_comb begin
    dec = '{
      handled:    1'b1,
      bus:        sls_pkg::BUS_NONE,
      addr_sel:   sls_pkg::ADDR_NONE,
      src_sel:    sls_pkg::SRC_REG,
      src_code:   sls_pkg::R_A,
      dst_write:  1'b0,
      dst_code:   sls_pkg::R_A,
      pair_write: 1'b0,
      pair_sel:   sls_pkg::PAIR_BC,
      hl_step:    sls_pkg::HL_KEEP
    };
    priority if (opcode >= sls_pkg::OP_MOVE_FIRST && opcode <= sls_pkg::OP_MOVE_LAST &&
                 opcode != sls_pkg::OP_HALT) begin
      priority if (src == sls_pkg::R_MEM) begin
        dec.bus       = sls_pkg::BUS_READ;
        dec.addr_sel  = sls_pkg::ADDR_HL;
        dec.src_sel   = sls_pkg::SRC_READ;
        dec.dst_write = 1'b1;
        dec.dst_code  = dst;
      end else if (dst == sls_pkg::R_MEM) begin
        dec.bus      = sls_pkg::BUS_WRITE;
        dec.addr_sel = sls_pkg::ADDR_HL;
        dec.src_code = src;
      end else begin
        dec.src_code  = src;
        dec.dst_write = 1'b1;
        dec.dst_code  = dst;
      end
    end else if (opcode < sls_pkg::OP_MOVE_FIRST && src == sls_pkg::R_MEM) begin
      dec.src_sel = sls_pkg::SRC_IMM8;
      if (dst == sls_pkg::R_MEM) begin
        dec.bus      = sls_pkg::BUS_WRITE;
        dec.addr_sel = sls_pkg::ADDR_HL;
      end else begin
        dec.dst_write = 1'b1;
        dec.dst_code  = dst;
      end
    end else begin
      // remaining forms all move A (or a pair), so src/dst default to A
      unique case (opcode)
        sls_pkg::OP_LD_BC_N16: begin
          dec.pair_write = 1'b1;
          dec.pair_sel   = sls_pkg::PAIR_BC;
        end
        sls_pkg::OP_LD_DE_N16: begin
          dec.pair_write = 1'b1;
          dec.pair_sel   = sls_pkg::PAIR_DE;
        end
        sls_pkg::OP_LD_HL_N16: begin
          dec.pair_write = 1'b1;
          dec.pair_sel   = sls_pkg::PAIR_HL;
        end
        sls_pkg::OP_ST_BC_A: begin
          dec.bus      = sls_pkg::BUS_WRITE;
          dec.addr_sel = sls_pkg::ADDR_BC;
        end
        sls_pkg::OP_ST_DE_A: begin
          dec.bus      = sls_pkg::BUS_WRITE;
          dec.addr_sel = sls_pkg::ADDR_DE;
        end
        sls_pkg::OP_LD_A_BC: begin
          dec.bus       = sls_pkg::BUS_READ;
          dec.addr_sel  = sls_pkg::ADDR_BC;
          dec.src_sel   = sls_pkg::SRC_READ;
          dec.dst_write = 1'b1;
        end
        sls_pkg::OP_LD_A_DE: begin
          dec.bus       = sls_pkg::BUS_READ;
          dec.addr_sel  = sls_pkg::ADDR_DE;
          dec.src_sel   = sls_pkg::SRC_READ;
          dec.dst_write = 1'b1;
        end
        sls_pkg::OP_ST_HLI_A: begin
          dec.bus      = sls_pkg::BUS_WRITE;
          dec.addr_sel = sls_pkg::ADDR_HL;
          dec.hl_step  = sls_pkg::HL_INC;
        end
        sls_pkg::OP_ST_HLD_A: begin
          dec.bus      = sls_pkg::BUS_WRITE;
          dec.addr_sel = sls_pkg::ADDR_HL;
          dec.hl_step  = sls_pkg::HL_DEC;
        end
        sls_pkg::OP_LD_A_HLI: begin
          dec.bus       = sls_pkg::BUS_READ;
          dec.addr_sel  = sls_pkg::ADDR_HL;
          dec.src_sel   = sls_pkg::SRC_READ;
          dec.dst_write = 1'b1;
          dec.hl_step   = sls_pkg::HL_INC;
        end
        sls_pkg::OP_LD_A_HLD: begin
          dec.bus       = sls_pkg::BUS_READ;
          dec.addr_sel  = sls_pkg::ADDR_HL;
          dec.src_sel   = sls_pkg::SRC_READ;
          dec.dst_write = 1'b1;
          dec.hl_step   = sls_pkg::HL_DEC;
        end
        sls_pkg::OP_STH_N8_A: begin
          dec.bus      = sls_pkg::BUS_WRITE;
          dec.addr_sel = sls_pkg::ADDR_HIGH_IMM;
        end
        sls_pkg::OP_STH_C_A: begin
          dec.bus      = sls_pkg::BUS_WRITE;
          dec.addr_sel = sls_pkg::ADDR_HIGH_C;
        end
        sls_pkg::OP_LDH_A_N8: begin
          dec.bus       = sls_pkg::BUS_READ;
          dec.addr_sel  = sls_pkg::ADDR_HIGH_IMM;
          dec.src_sel   = sls_pkg::SRC_READ;
          dec.dst_write = 1'b1;
        end
        sls_pkg::OP_LDH_A_C: begin
          dec.bus       = sls_pkg::BUS_READ;
          dec.addr_sel  = sls_pkg::ADDR_HIGH_C;
          dec.src_sel   = sls_pkg::SRC_READ;
          dec.dst_write = 1'b1;
        end
        sls_pkg::OP_ST_A16_A: begin
          dec.bus      = sls_pkg::BUS_WRITE;
          dec.addr_sel = sls_pkg::ADDR_IMM16;
        end
        sls_pkg::OP_LD_A_A16: begin
          dec.bus       = sls_pkg::BUS_READ;
          dec.addr_sel  = sls_pkg::ADDR_IMM16;
          dec.src_sel   = sls_pkg::SRC_READ;
          dec.dst_write = 1'b1;
        end
        default: begin
          dec.handled = 1'b0;
        end
      endcase
    end
  end

  assign in_ready    = ~q_full;
  assign push        = in_valid & ~q_full;
  assign entry.dec   = dec;
  assign entry.imm   = immediate;
  assign entry.rdata = read_byte;

endmodule

// ===== hw/rtl/sls_queue.sv =====
// Short FIFO of decoded instructions between the front end and the execute stage.
module sls_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sls_pkg::queue_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  q_valid,
  output sls_pkg::queue_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sls_pkg::queue_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_FULL);
  assign q_valid = (count != '0);
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("transfer into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !q_valid |-> !pop)
    else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/sls_execute.sv =====
// Back end: holds A and B..L; one decoded load per cycle into an output register unless stalled.
module sls_execute (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  sls_pkg::queue_entry_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  handled,
  output logic [1:0]            bus_op,
  output logic [15:0]           bus_address,
  output logic [7:0]            write_byte,
  output logic [7:0]            reg_a,
  output logic [15:0]           pair_bc,
  output logic [15:0]           pair_de,
  output logic [15:0]           pair_hl
);

  logic [7:0] acc, reg_b, reg_c, reg_d, reg_e, reg_h, reg_l;
  logic [7:0] acc_next, reg_b_next, reg_c_next, reg_d_next;
  logic [7:0] reg_e_next, reg_h_next, reg_l_next;
  logic       handled_reg;
  sls_pkg::bus_op_t bus_reg;
  logic [15:0] addr_reg;
  logic [7:0]  wbyte_reg;

  sls_pkg::decoded_t dec;
  logic [15:0] hl;
  logic [15:0] hl_stepped;
  logic [7:0]  src_reg;
  logic [7:0]  value;
  logic [15:0] addr;

  assign dec = head.dec;
  assign hl  = {reg_h, reg_l};
  // registers stay put while a result waits, so they show the post-instruction state
  assign pop = q_valid & (~out_valid | out_ready);

  always_comb begin
    unique case (dec.src_code)
      sls_pkg::R_B: src_reg = reg_b;
      sls_pkg::R_C: src_reg = reg_c;
      sls_pkg::R_D: src_reg = reg_d;
      sls_pkg::R_E: src_reg = reg_e;
      sls_pkg::R_H: src_reg = reg_h;
      sls_pkg::R_L: src_reg = reg_l;
      sls_pkg::R_A: src_reg = acc;
      default:      src_reg = '0;
    endcase
  end

  always_comb begin
    unique case (dec.src_sel)
      sls_pkg::SRC_REG:  value = src_reg;
      sls_pkg::SRC_IMM8: value = head.imm[7:0];
      sls_pkg::SRC_READ: value = head.rdata;
      default:           value = '0;
    endcase
  end

  always_comb begin
    unique case (dec.addr_sel)
      sls_pkg::ADDR_NONE:     addr = '0;
      sls_pkg::ADDR_HL:       addr = hl;
      sls_pkg::ADDR_BC:       addr = {reg_b, reg_c};
      sls_pkg::ADDR_DE:       addr = {reg_d, reg_e};
      sls_pkg::ADDR_IMM16:    addr = head.imm;
      sls_pkg::ADDR_HIGH_IMM: addr = sls_pkg::HIGH_PAGE | {8'h00, head.imm[7:0]};
      sls_pkg::ADDR_HIGH_C:   addr = sls_pkg::HIGH_PAGE | {8'h00, reg_c};
      default:                addr = '0;
    endcase
  end

  always_comb begin
    unique case (dec.hl_step)
      sls_pkg::HL_INC: hl_stepped = hl + 16'd1;
      sls_pkg::HL_DEC: hl_stepped = hl - 16'd1;
      default:         hl_stepped = hl;
    endcase
  end

  always_comb begin
    acc_next   = acc;
    reg_b_next = reg_b;
    reg_c_next = reg_c;
    reg_d_next = reg_d;
    reg_e_next = reg_e;
    {reg_h_next, reg_l_next} = hl_stepped;
    if (dec.dst_write) begin
      unique case (dec.dst_code)
        sls_pkg::R_B: reg_b_next = value;
        sls_pkg::R_C: reg_c_next = value;
        sls_pkg::R_D: reg_d_next = value;
        sls_pkg::R_E: reg_e_next = value;
        sls_pkg::R_H: reg_h_next = value;
        sls_pkg::R_L: reg_l_next = value;
        sls_pkg::R_A: acc_next   = value;
        default: ;
      endcase
    end
    if (dec.pair_write) begin
      unique case (dec.pair_sel)
        sls_pkg::PAIR_BC: {reg_b_next, reg_c_next} = head.imm;
        sls_pkg::PAIR_DE: {reg_d_next, reg_e_next} = head.imm;
        sls_pkg::PAIR_HL: {reg_h_next, reg_l_next} = head.imm;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      reg_b <= '0;
      reg_c <= '0;
      reg_d <= '0;
      reg_e <= '0;
      reg_h <= '0;
      reg_l <= '0;
    end else if (pop) begin
      acc   <= acc_next;
      reg_b <= reg_b_next;
      reg_c <= reg_c_next;
      reg_d <= reg_d_next;
      reg_e <= reg_e_next;
      reg_h <= reg_h_next;
      reg_l <= reg_l_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      handled_reg <= dec.handled;
      bus_reg     <= dec.bus;
      addr_reg    <= addr;
      wbyte_reg   <= (dec.bus == sls_pkg::BUS_WRITE) ? value : 8'h00;
    end
  end

  assign handled     = handled_reg;
  assign bus_op      = bus_reg;
  assign bus_address = addr_reg;
  assign write_byte  = wbyte_reg;
  assign reg_a       = acc;
  assign pair_bc     = {reg_b, reg_c};
  assign pair_de     = {reg_d, reg_e};
  assign pair_hl     = hl;

`ifndef SYNTHESIS
  a_state_held: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> $stable(acc) && $stable(hl) && $stable(pair_bc) &&
                                  $stable(pair_de))
    else $error("register file moved while result stalled");
  a_unhandled_quiet: assert property (@(posedge clk) disable iff (rst)
      out_valid && !handled |-> bus_op == sls_pkg::BUS_NONE)
    else $error("bus access on unhandled opcode");
  a_idle_bus_zero: assert property (@(posedge clk) disable iff (rst)
      out_valid && bus_op == sls_pkg::BUS_NONE |-> bus_address == '0 && write_byte == '0)
    else $error("address or data set without access");
  a_unhandled_no_change: assert property (@(posedge clk) disable iff (rst)
      pop && !dec.handled |=> $stable(acc) && $stable(hl) && $stable(pair_bc) &&
                              $stable(pair_de))
    else $error("unhandled opcode changed registers");
`endif

endmodule

// ===== hw/rtl/sm83_load_store_group.sv =====
// A result reaches the outputs through the queue and then the execute output register.
// Throughput: one instruction per cycle while out_ready stays high; otherwise the queue fills.
// The decode queue (QUEUE_DEPTH entries) absorbs output stalls; input stalls only when it is full.
// Output side is a register stage, so a waiting result does not stop the next input transfer.
// Reset (rst, synchronous): A, B, C, D, E, H, L cleared, queue emptied, no result pending.
module sm83_load_store_group #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  opcode,
  input  logic [15:0] immediate,
  input  logic [7:0]  read_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        handled,
  output logic [1:0]  bus_op,
  output logic [15:0] bus_address,
  output logic [7:0]  write_byte,
  output logic [7:0]  reg_a,
  output logic [15:0] pair_bc,
  output logic [15:0] pair_de,
  output logic [15:0] pair_hl
);

  logic                  push;
  logic                  q_full;
  logic                  q_valid;
  logic                  pop;
  sls_pkg::queue_entry_t push_entry;
  sls_pkg::queue_entry_t head;

  sls_decode u_decode (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .immediate (immediate),
    .read_byte (read_byte),
    .q_full    (q_full),
    .push      (push),
    .entry     (push_entry)
  );

  sls_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head)
  );

  sls_execute u_execute (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .handled     (handled),
    .bus_op      (bus_op),
    .bus_address (bus_address),
    .write_byte  (write_byte),
    .reg_a       (reg_a),
    .pair_bc     (pair_bc),
    .pair_de     (pair_de),
    .pair_hl     (pair_hl)
  );

endmodule
